// File: rtl/ctk_pkg.sv
// Package: shared types, constants and the day table for the radio clock frame decoder.
`timescale 1ns / 1ps
package ctk_pkg;

	localparam int TickW = 32;
	localparam int ValW  = 7;
	localparam int PosW  = 5;
	localparam int StepW = 3;

	localparam logic [PosW-1:0]  LastPos   = 5'd23;
	localparam logic [StepW-1:0] StepBase  = 3'd0;
	localparam logic [StepW-1:0] StepHour  = 3'd1;
	localparam logic [StepW-1:0] StepMin   = 3'd2;
	localparam logic [StepW-1:0] StepSec   = 3'd3;
	localparam logic [StepW-1:0] StepTenth = 3'd4;
	localparam logic [StepW-1:0] StepLast  = 3'd5;

	localparam logic [6:0] ChCr    = 7'h0D;
	localparam logic [6:0] ChTab   = 7'h09;
	localparam logic [6:0] ChLf    = 7'h0A;
	localparam logic [6:0] ChVt    = 7'h0B;
	localparam logic [6:0] ChFf    = 7'h0C;
	localparam logic [6:0] ChSpace = 7'h20;
	localparam logic [6:0] ChColon = 7'h3A;
	localparam logic [6:0] ChDot   = 7'h2E;
	localparam logic [6:0] ChSlash = 7'h2F;
	localparam logic [6:0] ChQuery = 7'h3F;
	localparam logic [6:0] ChZero  = 7'h30;
	localparam logic [6:0] ChNine  = 7'h39;

	localparam logic [TickW-1:0] TickOffsetReset = 32'h1000_0000;

	typedef struct packed {
		logic             take;      // input item accepted
		logic             calc;      // one step of the tick chain
		logic [StepW-1:0] step;
	} ctk_cmd_t;

	typedef struct packed {
		logic last_pos;              // next frame byte closes the frame
	} ctk_sts_t;

	// days in the year before the first of the given month
	function automatic logic [8:0] days_before(input logic [ValW-1:0] month);
		logic [8:0] d;
		unique case (month)
			7'd2:    d = 9'd31;
			7'd3:    d = 9'd59;
			7'd4:    d = 9'd90;
			7'd5:    d = 9'd120;
			7'd6:    d = 9'd151;
			7'd7:    d = 9'd181;
			7'd8:    d = 9'd212;
			7'd9:    d = 9'd243;
			7'd10:   d = 9'd273;
			7'd11:   d = 9'd304;
			7'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/ctk_ctrl.sv
// Controller: byte intake, tick chain sequencing and output valid.
`timescale 1ns / 1ps
module ctk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ctk_pkg::ctk_sts_t sts,
	output ctk_pkg::ctk_cmd_t cmd
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_CALC = 1'b1;

	logic [0:0]                state_q;
	logic [ctk_pkg::StepW-1:0] step_q;
	logic                      out_valid_q;
	logic                      take;
	logic                      load_out;

	assign in_ready  = (state_q == ST_IDLE) && !(sts.last_pos && out_valid_q);
	assign take      = in_valid && in_ready;
	assign load_out  = (state_q == ST_CALC) && (step_q == ctk_pkg::StepLast);
	assign out_valid = out_valid_q;

	assign cmd.take = take;
	assign cmd.calc = (state_q == ST_CALC);
	assign cmd.step = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= ctk_pkg::StepBase;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take && sts.last_pos) begin
						state_q <= ST_CALC;
						step_q  <= ctk_pkg::StepBase;
					end
				end
				ST_CALC: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_calc_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> !in_ready)
		else $error("input taken during tick chain");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (step_q <= ctk_pkg::StepLast))
		else $error("tick chain step out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q)
		else $error("result loaded over a pending item");

	a_last_starts_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(take && sts.last_pos) |=> (state_q == ST_CALC && step_q == ctk_pkg::StepBase))
		else $error("frame end did not start tick chain");

endmodule

// File: rtl/ctk_datapath.sv
// Datapath: frame parser registers, tick chain multiplier and result register.
`timescale 1ns / 1ps
module ctk_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                link_byte,
	input  logic                      cfg_valid,
	input  logic [ctk_pkg::TickW-1:0] cfg_data,
	input  ctk_pkg::ctk_cmd_t         cmd,
	output ctk_pkg::ctk_sts_t         sts,
	output logic                      format_error,
	output logic [ctk_pkg::TickW-1:0] time_ticks
);

	logic                       hunting_q;
	logic [ctk_pkg::PosW-1:0]   pos_q;
	logic [ctk_pkg::ValW-1:0]   hour_q, minute_q, second_q, month_q, day_q, year_q;
	logic [3:0]                 tenth_q;
	logic                       bad_layout_q;
	logic [ctk_pkg::TickW-1:0]  offset_q;
	logic [ctk_pkg::TickW-1:0]  acc_q;
	logic                       range_bad_q;
	logic                       res_err_q;
	logic [ctk_pkg::TickW-1:0]  res_ticks_q;

	logic [6:0]                 b;
	logic                       is_digit;
	logic [3:0]                 digit;
	logic                       is_space;
	logic                       range_bad;
	logic                       leap;
	logic [ctk_pkg::TickW-1:0]  base;
	logic [ctk_pkg::TickW-1:0]  k32;
	logic [ctk_pkg::TickW-1:0]  addend;
	logic [ctk_pkg::TickW-1:0]  prod;
	logic [ctk_pkg::TickW-1:0]  next_acc;

	assign b        = link_byte[6:0];
	assign is_digit = (b >= ctk_pkg::ChZero) && (b <= ctk_pkg::ChNine);
	assign digit    = is_digit ? 4'(b - ctk_pkg::ChZero) : 4'd0;
	assign is_space = (b == ctk_pkg::ChSpace) || (b == ctk_pkg::ChTab) ||
		(b == ctk_pkg::ChLf) || (b == ctk_pkg::ChVt) ||
		(b == ctk_pkg::ChFf) || (b == ctk_pkg::ChCr);

	assign sts.last_pos = !hunting_q && (pos_q == ctk_pkg::LastPos);

	function automatic logic [6:0] acc_digit(input logic [6:0] prev, input logic [3:0] d);
		logic [10:0] v;
		v = 11'(prev) * 11'd10 + 11'(d);
		return v[6:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			pos_q     <= '0;
		end else if (cmd.take) begin
			if (hunting_q) begin
				if (b == ctk_pkg::ChCr) begin
					hunting_q <= 1'b0;
					pos_q     <= '0;
				end
			end else if (pos_q == ctk_pkg::LastPos) begin
				hunting_q <= 1'b1;
				pos_q     <= '0;
			end else begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (hunting_q) begin
				if (b == ctk_pkg::ChCr) begin
					hour_q       <= '0;
					minute_q     <= '0;
					second_q     <= '0;
					tenth_q      <= '0;
					month_q      <= '0;
					day_q        <= '0;
					year_q       <= '0;
					bad_layout_q <= 1'b0;
				end
			end else begin
				unique case (pos_q)
					5'd0, 5'd1: begin
						hour_q <= acc_digit(hour_q, digit);
						if (!is_digit) bad_layout_q <= 1'b1;
					end
					5'd3, 5'd4: begin
						minute_q <= acc_digit(minute_q, digit);
						if (!is_digit) bad_layout_q <= 1'b1;
					end
					5'd6, 5'd7: begin
						second_q <= acc_digit(second_q, digit);
						if (!is_digit) bad_layout_q <= 1'b1;
					end
					5'd9: begin
						if (b == ctk_pkg::ChQuery) begin
							tenth_q <= 4'd0;
						end else begin
							tenth_q <= digit;
							if (!is_digit) bad_layout_q <= 1'b1;
						end
					end
					5'd14, 5'd15: begin
						month_q <= acc_digit(month_q, digit);
						if (!is_digit) bad_layout_q <= 1'b1;
					end
					5'd17, 5'd18: begin
						day_q <= acc_digit(day_q, digit);
						if (!is_digit) bad_layout_q <= 1'b1;
					end
					5'd20, 5'd21: begin
						year_q <= acc_digit(year_q, digit);
						if (!is_digit) bad_layout_q <= 1'b1;
					end
					5'd2, 5'd5: begin
						if (b != ctk_pkg::ChColon) bad_layout_q <= 1'b1;
					end
					5'd8: begin
						if (b != ctk_pkg::ChDot) bad_layout_q <= 1'b1;
					end
					5'd16, 5'd19: begin
						if (b != ctk_pkg::ChSlash) bad_layout_q <= 1'b1;
					end
					5'd10, 5'd11, 5'd12, 5'd13: begin
						if (!is_space) bad_layout_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= ctk_pkg::TickOffsetReset;
		end else if (cfg_valid) begin
			offset_q <= cfg_data;
		end
	end

	assign range_bad = bad_layout_q || (month_q < 7'd1) || (month_q > 7'd12) ||
		(day_q > 7'd31) || (minute_q > 7'd59) || (second_q > 7'd59) ||
		(tenth_q > 4'd9) || (hour_q > 7'd23);
	assign leap = (year_q[1:0] == 2'd0) && (month_q >= 7'd3);
	assign base = 32'(leap) + 32'(ctk_pkg::days_before(month_q)) + 32'(day_q) - 32'd1;

	always_comb begin
		unique case (cmd.step)
			ctk_pkg::StepHour: begin
				k32    = 32'd24;
				addend = 32'(hour_q);
			end
			ctk_pkg::StepMin: begin
				k32    = 32'd60;
				addend = 32'(minute_q);
			end
			ctk_pkg::StepSec: begin
				k32    = 32'd60;
				addend = 32'(second_q);
			end
			ctk_pkg::StepTenth: begin
				k32    = 32'd10;
				addend = 32'(tenth_q);
			end
			ctk_pkg::StepLast: begin
				k32    = 32'd10;
				addend = offset_q;
			end
			default: begin
				k32    = 32'd0;
				addend = base;
			end
		endcase
	end

	assign prod     = acc_q * k32;
	assign next_acc = prod + addend;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			acc_q <= next_acc;
			if (cmd.step == ctk_pkg::StepBase) begin
				range_bad_q <= range_bad;
			end
			if (cmd.step == ctk_pkg::StepLast) begin
				res_err_q   <= range_bad_q;
				res_ticks_q <= range_bad_q ? '0 : next_acc;
			end
		end
	end

	assign format_error = res_err_q;
	assign time_ticks   = res_ticks_q;

endmodule

// File: rtl/clock_frame_to_ticks_core.sv
// Top level: radio clock frame decoder giving hundredths of a second since year start plus tick_offset.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_ready       link_byte[7:0]
//   out      output     out_valid / out_ready     format_error, time_ticks[31:0]
//   cfg      input      cfg_valid / cfg_ready     cfg_data[31:0] (tick_offset)
//
// The 24th frame byte starts the tick chain (one constant multiply and add per cycle),
// during which in_ready is low. The result sits in an output register; bytes keep
// flowing while it waits, except the closing byte of the next frame, which stalls until
// the pending item is taken.
// Reset puts the decoder hunting for a carriage return with tick_offset at 0x10000000.
// cfg_ready is always high.
`timescale 1ns / 1ps
module clock_frame_to_ticks_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  link_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        format_error,
	output logic [31:0] time_ticks,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	ctk_pkg::ctk_cmd_t cmd;
	ctk_pkg::ctk_sts_t sts;

	assign cfg_ready = 1'b1;

	ctk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ctk_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.link_byte    (link_byte),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.format_error (format_error),
		.time_ticks   (time_ticks)
	);

endmodule
